// ===== rtl/pqne_pkg.sv =====
// Shared types and constants for the 4-bit product-quantization encoder.
// Used by pqne_dist_unit and pq_nibble_encoder; depends on nothing.
`default_nettype none

package pqne_pkg;

    // Fixed geometry of the codebook and the centroid store
    localparam int CENTROIDS       = 16;
    localparam int CENT_BITS       = 4;
    localparam int STORE_ADDR_BITS = 14;
    localparam int STORE_DEPTH     = 1 << STORE_ADDR_BITS;
    localparam int SAMPLE_BITS     = 16;
    localparam int DIFF_BITS       = SAMPLE_BITS + 1;
    localparam int SQ_BITS         = 2 * SAMPLE_BITS;
    localparam int ACC_BITS        = 40;

    // Vector geometry limits
    localparam int COUNT_BITS      = 11;
    localparam int LEN_BITS        = 7;
    localparam int MAX_SUBSPACES   = 1024;
    localparam int MAX_SUB_LEN     = 64;
    localparam int ELEM_BITS       = 6;
    localparam int SUB_BITS        = 10;
    localparam int BYTE_IDX_BITS   = 9;

    // Port widths
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 11;
    localparam int S_TDATA_BITS    = 32;
    localparam int M_TDATA_BITS    = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SUB_COUNT  = 2'd0,
        CFG_SUB_LENGTH = 2'd1
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Control from the sequencer to the distance unit
    typedef struct packed {
        logic                       wr_en;
        logic [STORE_ADDR_BITS-1:0] wr_addr;
        logic                       rd_en;
        logic [STORE_ADDR_BITS-1:0] rd_addr;
        logic [CENT_BITS-1:0]       rd_cent;
        logic                       final_elem;
        logic                       clear_all;
    } t_dist_ctrl;

endpackage

`default_nettype wire

// ===== rtl/pqne_dist_unit.sv =====
// Centroid store plus the shared subtract/square/accumulate unit and argmin tracker.
// Depends on pqne_pkg; driven by the sequencer in pq_nibble_encoder.
`default_nettype none

module pqne_dist_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pqne_pkg::t_dist_ctrl              i_ctrl,
    input  wire logic [pqne_pkg::SAMPLE_BITS-1:0]  i_wr_data,
    input  wire logic [pqne_pkg::SAMPLE_BITS-1:0]  i_sample,
    output logic                                   o_busy,
    output logic      [pqne_pkg::CENT_BITS-1:0]    o_best_idx
);
    import pqne_pkg::*;

    logic [SAMPLE_BITS-1:0] r_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_word;

    logic                   r_p1_vld;
    logic [CENT_BITS-1:0]   r_p1_c;
    logic                   r_p1_fin;
    logic                   r_p2_vld;
    logic [CENT_BITS-1:0]   r_p2_c;
    logic                   r_p2_fin;
    logic [SQ_BITS-1:0]     r_sq;
    logic [SQ_BITS-1:0]     n_sq;

    logic [ACC_BITS-1:0]    r_acc [CENTROIDS];
    logic [ACC_BITS-1:0]    r_best;
    logic [CENT_BITS-1:0]   r_best_idx;

    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [2*DIFF_BITS-1:0] prod;
    logic [ACC_BITS:0]             sum;
    logic [ACC_BITS-1:0]           acc_sat;
    logic                          take_best;

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_word <= r_mem[i_ctrl.rd_addr];
        end
    end

    // Squared difference of sample and centroid word
    always_comb begin
        diff = DIFF_BITS'(signed'(i_sample)) - DIFF_BITS'(signed'(r_word));
        prod = diff * diff;
        n_sq = prod[SQ_BITS-1:0];
    end

    // Saturating accumulate and running minimum on the final element
    always_comb begin
        sum       = {1'b0, r_acc[r_p2_c]} + (ACC_BITS+1)'(r_sq);
        acc_sat   = sum[ACC_BITS] ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];
        take_best = r_p2_vld && r_p2_fin && ((r_p2_c == '0) || (acc_sat < r_best));
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_ctrl.rd_en;
            r_p2_vld <= r_p1_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_p1_c   <= i_ctrl.rd_cent;
        r_p1_fin <= i_ctrl.final_elem;
        r_p2_c   <= r_p1_c;
        r_p2_fin <= r_p1_fin;
        r_sq     <= n_sq;
        if (take_best) begin
            r_best <= acc_sat;
        end
    end

    // Accumulators: clear on restart, zero after the final element is scored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CENTROIDS; i++) begin
                r_acc[i] <= '0;
            end
            r_best_idx <= '0;
        end else begin
            if (i_ctrl.clear_all) begin
                for (int i = 0; i < CENTROIDS; i++) begin
                    r_acc[i] <= '0;
                end
            end else if (r_p2_vld) begin
                r_acc[r_p2_c] <= r_p2_fin ? '0 : acc_sat;
            end
            if (take_best) begin
                r_best_idx <= r_p2_c;
            end
        end
    end

    assign o_busy     = r_p1_vld | r_p2_vld;
    assign o_best_idx = r_best_idx;

endmodule

`default_nettype wire

// ===== rtl/pq_nibble_encoder.sv =====
// Top level of the 4-bit product-quantization encoder: ports, sequencer, output register.
// Depends on pqne_pkg and pqne_dist_unit.
//
// Usage:
//  - Slave stream: tuser = 0 writes a codebook word at the flat store address,
//    tuser = 1 delivers the next vector sample (address ignored).
//  - Config channel: index 0 = subspace count, index 1 = subspace length.
//    A write restarts the current vector; zero reads as 1, large values clamp.
//  - Master stream: one code byte per two subspaces (or one at an odd end),
//    tlast on the final byte of each vector.
// Timing:
//  - A sample is accepted, then 16 store reads are issued (one per centroid,
//    set by the single store read port), the subtract/square/accumulate
//    pipe drains, and a finishing state follows.
//  - The code byte is registered into the output register from that finishing state.
// Reset clears positions, accumulators and the output valid flag, and loads
// count = 8, length = 8; the centroid store holds garbage until written.
// A stalled receiver holds the byte; the next subspace end waits for it,
// while samples and codebook writes are still accepted until then.
`default_nettype none

module pq_nibble_encoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // [13:0] store_address, [29:14] sample_value, [31:30] zero
    input  wire logic [pqne_pkg::S_TDATA_BITS-1:0]   i_s_tdata,
    // [0] kind
    input  wire logic                                i_s_tuser,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [7:0] code_byte, [16:8] byte_index, [23:17] zero
    output logic      [pqne_pkg::M_TDATA_BITS-1:0]   o_m_tdata,
    output logic                                     o_m_tlast,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pqne_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [pqne_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import pqne_pkg::*;

    t_state                     r_state, n_state;
    logic [CENT_BITS-1:0]       r_cnt, n_cnt;
    logic [STORE_ADDR_BITS-1:0] r_addr, n_addr;
    logic [STORE_ADDR_BITS-1:0] r_sub_base, n_sub_base;
    logic [ELEM_BITS-1:0]       r_elem, n_elem;
    logic [SUB_BITS-1:0]        r_sub, n_sub;
    logic [CENT_BITS-1:0]       r_pend, n_pend;
    logic [COUNT_BITS-1:0]      r_count, n_count;
    logic [LEN_BITS-1:0]        r_len, n_len;
    logic [SAMPLE_BITS-1:0]     r_x, n_x;
    logic                       r_fin, n_fin;
    logic                       r_out_vld, n_out_vld;
    logic [7:0]                 r_out_byte, n_out_byte;
    logic [BYTE_IDX_BITS-1:0]   r_out_idx, n_out_idx;
    logic                       r_out_last, n_out_last;

    t_dist_ctrl                 dist_ctrl;
    logic                       dist_busy;
    logic [CENT_BITS-1:0]       best_idx;
    logic                       s_fire;
    logic                       cfg_fire;
    logic                       last_sub;
    logic [COUNT_BITS-1:0]      cfg_count;
    logic [LEN_BITS-1:0]        cfg_len;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_fire      = i_s_tvalid & o_s_tready;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;
    assign last_sub    = (({1'b0, r_sub} + COUNT_BITS'(1)) >= r_count);

    // Clamp configuration values into range
    always_comb begin
        cfg_count = i_cfg_data[COUNT_BITS-1:0];
        if (cfg_count == '0) begin
            cfg_count = COUNT_BITS'(1);
        end else if (cfg_count > COUNT_BITS'(MAX_SUBSPACES)) begin
            cfg_count = COUNT_BITS'(MAX_SUBSPACES);
        end
        cfg_len = i_cfg_data[LEN_BITS-1:0];
        if (cfg_len == '0) begin
            cfg_len = LEN_BITS'(1);
        end else if (cfg_len > LEN_BITS'(MAX_SUB_LEN)) begin
            cfg_len = LEN_BITS'(MAX_SUB_LEN);
        end
    end

    // Sequencer: next state and unit control
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_addr     = r_addr;
        n_sub_base = r_sub_base;
        n_elem     = r_elem;
        n_sub      = r_sub;
        n_pend     = r_pend;
        n_count    = r_count;
        n_len      = r_len;
        n_x        = r_x;
        n_fin      = r_fin;
        n_out_vld  = r_out_vld;
        n_out_byte = r_out_byte;
        n_out_idx  = r_out_idx;
        n_out_last = r_out_last;

        dist_ctrl            = '0;
        dist_ctrl.wr_addr    = i_s_tdata[STORE_ADDR_BITS-1:0];
        dist_ctrl.rd_addr    = r_addr;
        dist_ctrl.rd_cent    = r_cnt;
        dist_ctrl.final_elem = r_fin;

        // Drop the output word once taken
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        // Register write: load and restart the vector
        if (cfg_fire) begin
            case (i_cfg_index)
                CFG_SUB_COUNT: begin
                    n_count = cfg_count;
                end
                CFG_SUB_LENGTH: begin
                    n_len = cfg_len;
                end
                default: begin
                end
            endcase
            if ((i_cfg_index == CFG_SUB_COUNT) || (i_cfg_index == CFG_SUB_LENGTH)) begin
                n_elem              = '0;
                n_sub               = '0;
                n_sub_base          = '0;
                n_pend              = '0;
                dist_ctrl.clear_all = 1'b1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    if (!i_s_tuser) begin
                        dist_ctrl.wr_en = 1'b1;
                    end else begin
                        n_x     = i_s_tdata[STORE_ADDR_BITS +: SAMPLE_BITS];
                        n_fin   = (({1'b0, r_elem} + LEN_BITS'(1)) == r_len);
                        n_addr  = r_sub_base + STORE_ADDR_BITS'(r_elem);
                        n_cnt   = '0;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                // Issue one centroid read per cycle
                dist_ctrl.rd_en = 1'b1;
                n_addr          = r_addr + STORE_ADDR_BITS'(r_len);
                n_cnt           = r_cnt + CENT_BITS'(1);
                if (r_cnt == CENT_BITS'(CENTROIDS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!dist_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_fin) begin
                    n_elem  = r_elem + ELEM_BITS'(1);
                    n_state = ST_IDLE;
                end else if (!r_out_vld || i_m_tready) begin
                    // Subspace done: place its nibble and advance
                    n_elem = '0;
                    if (!r_sub[0]) begin
                        if (last_sub) begin
                            n_out_vld  = 1'b1;
                            n_out_byte = {4'b0, best_idx};
                            n_out_idx  = r_sub[SUB_BITS-1:1];
                            n_out_last = 1'b1;
                        end else begin
                            n_pend = best_idx;
                        end
                    end else begin
                        n_out_vld  = 1'b1;
                        n_out_byte = {best_idx, r_pend};
                        n_out_idx  = r_sub[SUB_BITS-1:1];
                        n_out_last = last_sub;
                        n_pend     = '0;
                    end
                    if (last_sub) begin
                        n_sub      = '0;
                        n_sub_base = '0;
                        n_pend     = '0;
                    end else begin
                        n_sub      = r_sub + SUB_BITS'(1);
                        n_sub_base = r_sub_base + STORE_ADDR_BITS'({r_len, 4'b0});
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_sub_base <= '0;
            r_elem     <= '0;
            r_sub      <= '0;
            r_pend     <= '0;
            r_count    <= COUNT_BITS'(8);
            r_len      <= LEN_BITS'(8);
            r_fin      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_sub_base <= n_sub_base;
            r_elem     <= n_elem;
            r_sub      <= n_sub;
            r_pend     <= n_pend;
            r_count    <= n_count;
            r_len      <= n_len;
            r_fin      <= n_fin;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_x        <= n_x;
        r_out_byte <= n_out_byte;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    pqne_dist_unit u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (dist_ctrl),
        .i_wr_data  (i_s_tdata[STORE_ADDR_BITS +: SAMPLE_BITS]),
        .i_sample   (r_x),
        .o_busy     (dist_busy),
        .o_best_idx (best_idx)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = M_TDATA_BITS'({r_out_idx, r_out_byte});

    // Checks
    a_idle_unit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !dist_busy)
        else $error("distance unit busy while sequencer idle");

    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt == CENT_BITS'(CENTROIDS - 1)) |=> (r_state == ST_DRAIN))
        else $error("centroid sweep did not end after the last centroid");

    a_elem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_elem} < r_len) && ({1'b0, r_sub} < r_count))
        else $error("element or subspace position out of range");

    a_last_byte_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_last)
            |-> (r_out_idx == BYTE_IDX_BITS'((r_count - COUNT_BITS'(1)) >> 1)))
        else $error("final byte index does not match subspace count");

endmodule

`default_nettype wire

// ===== test/pq_nibble_encoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pq_nibble_encoder: loads codebooks, streams vectors under
// random gaps and stalls, and checks each code byte against an encoder kept in the bench.
// Depends on pqne_pkg and the pq_nibble_encoder RTL.

module pq_nibble_encoder_tb;
    import pqne_pkg::*;

    localparam logic KIND_CODEBOOK = 1'b0;
    localparam logic KIND_SAMPLE   = 1'b1;
    // Settle time after quiet: lets one sample pass through the block, with margin
    localparam int   BLOCK_CYCLES  = 24;
    localparam int   STALL_LIMIT   = 2000;
    localparam int   SEG_ITEMS     = 250;
    localparam int   PRINT_LIMIT   = 100;
    localparam longint unsigned ACC_MAX = (64'd1 << ACC_BITS) - 1;

    typedef struct packed {
        logic                          kind;
        logic [STORE_ADDR_BITS-1:0]    addr;
        logic signed [SAMPLE_BITS-1:0] value;
    } t_word_in;

    typedef struct packed {
        logic [7:0]               code;
        logic [BYTE_IDX_BITS-1:0] idx;
        logic                     last;
    } t_code_out;

    // Block ports
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic [S_TDATA_BITS-1:0]  i_s_tdata   = '0;
    logic                     i_s_tuser   = 1'b0;
    logic                     i_s_tvalid  = 1'b0;
    logic                     o_s_tready;
    logic [M_TDATA_BITS-1:0]  o_m_tdata;
    logic                     o_m_tlast;
    logic                     o_m_tvalid;
    logic                     i_m_tready  = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    t_cfg_reg                 i_cfg_index = CFG_SUB_COUNT;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    // Encoder state mirrored in the bench
    logic signed [SAMPLE_BITS-1:0] cb_mem [STORE_DEPTH];
    longint unsigned               dist_acc [CENTROIDS];
    int unsigned                   elem_pos  = 0;
    int unsigned                   sub_pos   = 0;
    int unsigned                   sub_count = 8;
    int unsigned                   sub_len   = 8;
    logic [CENT_BITS-1:0]          low_nib   = '0;

    // Stimulus and expected code bytes
    t_word_in    stim_q [$];
    t_word_in    cur_word;
    t_code_out   code_fifo [$];
    t_code_out   expected_byte;
    bit          cb_filled [STORE_DEPTH];
    int unsigned push_cnt       = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned stall_cycles   = 0;
    int          err_count      = 0;

    pq_nibble_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        err_count++;
    endtask

    // Drop all progress of the current vector
    function automatic void clear_vector();
        int c;
        elem_pos = 0;
        sub_pos  = 0;
        low_nib  = '0;
        for (c = 0; c < CENTROIDS; c++) begin
            dist_acc[c] = 0;
        end
    endfunction

    // Advance the encoder by one accepted word and queue the code byte it completes
    task automatic predict_word(input t_word_in w);
        int              c;
        int unsigned     flat;
        int unsigned     best_c;
        longint          d;
        longint unsigned sum;
        longint unsigned best;
        bit              at_end;
        t_code_out       r;
        if (w.kind == KIND_CODEBOOK) begin
            cb_mem[w.addr] = w.value;
        end else begin
            for (c = 0; c < CENTROIDS; c++) begin
                flat = ((sub_pos * CENTROIDS + c) * sub_len + elem_pos) % STORE_DEPTH;
                d = longint'(w.value) - longint'(cb_mem[flat]);
                sum = dist_acc[c] + d * d;
                dist_acc[c] = (sum > ACC_MAX) ? ACC_MAX : sum;
            end
            elem_pos++;
            if (elem_pos >= sub_len) begin
                elem_pos = 0;
                // first strictly smallest distance wins
                best   = dist_acc[0];
                best_c = 0;
                for (c = 1; c < CENTROIDS; c++) begin
                    if (dist_acc[c] < best) begin
                        best   = dist_acc[c];
                        best_c = c;
                    end
                end
                for (c = 0; c < CENTROIDS; c++) begin
                    dist_acc[c] = 0;
                end
                at_end = (sub_pos + 1 >= sub_count);
                r.idx  = BYTE_IDX_BITS'(sub_pos / 2);
                r.last = at_end;
                if (sub_pos % 2 == 0) begin
                    if (at_end) begin
                        r.code = {4'h0, 4'(best_c)};
                        code_fifo.push_back(r);
                    end else begin
                        low_nib = 4'(best_c);
                    end
                end else begin
                    r.code = {4'(best_c), low_nib};
                    code_fifo.push_back(r);
                    low_nib = '0;
                end
                if (at_end) begin
                    sub_pos = 0;
                    low_nib = '0;
                end else begin
                    sub_pos++;
                end
            end
        end
    endtask

    // Write one register and mirror it: zero reads as one, large values clamp
    task automatic cfg_write(input t_cfg_reg reg_idx, input logic [CFG_DATA_BITS-1:0] val);
        int unsigned v;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (reg_idx)
            CFG_SUB_COUNT: begin
                v = val;
                sub_count = (v == 0) ? 1 : (v > MAX_SUBSPACES) ? MAX_SUBSPACES : v;
            end
            CFG_SUB_LENGTH: begin
                v = val[LEN_BITS-1:0];
                sub_len = (v == 0) ? 1 : (v > MAX_SUB_LEN) ? MAX_SUB_LEN : v;
            end
            default: ;
        endcase
        clear_vector();
    endtask

    // Hold until every word is taken and every byte is out, then let the pipe empty
    task automatic wait_quiet();
        do @(negedge i_clk); while (stim_q.size() != 0 || i_s_tvalid || code_fifo.size() != 0);
        repeat (BLOCK_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
        case ($urandom_range(7))
            0:       pick_value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            // narrow values make equal distances common
            1, 2:    pick_value = 16'($urandom_range(6) - 3);
            default: pick_value = 16'($urandom);
        endcase
    endfunction

    task automatic push_word(input logic kind, input logic [STORE_ADDR_BITS-1:0] addr,
                             input logic signed [SAMPLE_BITS-1:0] value);
        t_word_in w;
        w.kind  = kind;
        w.addr  = addr;
        w.value = value;
        if (kind == KIND_CODEBOOK) begin
            cb_filled[addr] = 1'b1;
        end
        stim_q.push_back(w);
        push_cnt++;
    endtask

    // Load every store entry the current geometry can read that holds nothing yet
    task automatic fill_codebook();
        int unsigned a;
        int unsigned span;
        span = sub_count * CENTROIDS * sub_len;
        if (span > STORE_DEPTH) begin
            span = STORE_DEPTH;
        end
        for (a = 0; a < span; a++) begin
            if (!cb_filled[a]) begin
                push_word(KIND_CODEBOOK, STORE_ADDR_BITS'(a), pick_value());
            end
        end
    endtask

    // Samples with random codebook rewrites mixed in between them
    task automatic queue_samples(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                push_word(KIND_CODEBOOK, STORE_ADDR_BITS'($urandom), pick_value());
            end
            push_word(KIND_SAMPLE, STORE_ADDR_BITS'($urandom), pick_value());
        end
    endtask

    // Random geometries, whole vectors, and now and then a vector cut short
    task automatic random_segment(input int unsigned target);
        int unsigned start_cnt;
        int unsigned per_vec;
        int unsigned n;
        start_cnt = push_cnt;
        while (push_cnt - start_cnt < target) begin
            wait_quiet();
            if ($urandom_range(5) == 0) begin
                cfg_write(CFG_SUB_LENGTH, CFG_DATA_BITS'($urandom_range(8, 5)));
                cfg_write(CFG_SUB_COUNT, CFG_DATA_BITS'($urandom_range(2)));
            end else if ($urandom_range(3) == 0) begin
                if ($urandom_range(1)) begin
                    cfg_write(CFG_SUB_COUNT, CFG_DATA_BITS'($urandom_range(3)));
                end else begin
                    cfg_write(CFG_SUB_LENGTH, CFG_DATA_BITS'($urandom_range(4)));
                end
            end else begin
                cfg_write(CFG_SUB_COUNT, CFG_DATA_BITS'($urandom_range(7)));
                cfg_write(CFG_SUB_LENGTH, CFG_DATA_BITS'($urandom_range(4)));
            end
            fill_codebook();
            per_vec = sub_count * sub_len;
            n = $urandom_range(3, 1) * per_vec;
            if ($urandom_range(2) == 0) begin
                n += $urandom_range(per_vec - 1);
            end
            queue_samples(n);
        end
    endtask

    // Input driver: present the next word, hold it until taken
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            predict_word(cur_word);
        end
        if (!i_s_tvalid || o_s_tready) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                cur_word = stim_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= cur_word.kind;
                i_s_tdata  <= S_TDATA_BITS'({cur_word.value, cur_word.addr});
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: stall at random, compare each taken word with the oldest expectation
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (code_fifo.size() == 0) begin
                report_mismatch($sformatf("code byte %h index %0d with none expected",
                                          o_m_tdata[7:0], o_m_tdata[16:8]));
            end else begin
                expected_byte = code_fifo.pop_front();
                if (o_m_tdata[7:0] !== expected_byte.code) begin
                    report_mismatch($sformatf("byte %0d: code %h, expected %h",
                                              expected_byte.idx, o_m_tdata[7:0],
                                              expected_byte.code));
                end
                if (o_m_tdata[16:8] !== expected_byte.idx) begin
                    report_mismatch($sformatf("byte index %0d, expected %0d",
                                              o_m_tdata[16:8], expected_byte.idx));
                end
                if (o_m_tlast !== expected_byte.last) begin
                    report_mismatch($sformatf("byte %0d: tlast %b, expected %b",
                                              expected_byte.idx, o_m_tlast, expected_byte.last));
                end
            end
        end
    end

    // Watchdog: end the run after too long without any handshake
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("pq_nibble_encoder test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned a;
        clear_vector();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles now and then, receiver stalls most of the time
        send_gap_pct   = 24;
        recv_stall_pct = 64;
        wait_quiet();

        // Three subspaces of one sample each
        cfg_write(CFG_SUB_COUNT, 3);
        cfg_write(CFG_SUB_LENGTH, 1);
        for (a = 0; a < 48; a++) begin
            push_word(KIND_CODEBOOK, STORE_ADDR_BITS'(a),
                      (a < 16) ? 16'sd7 : (a < 32) ? pick_value() : 16'sh7FFF);
        end
        push_word(KIND_CODEBOOK, 20, 16'sh8000);
        push_word(KIND_CODEBOOK, 25, 16'sh8000);
        push_word(KIND_CODEBOOK, 47, 16'sh8000);
        // all centroids equal: the tie goes to centroid 0
        push_word(KIND_SAMPLE, 0, 16'sh7FFF);
        // exact matches at centroids 4 and 9: the lower one wins
        push_word(KIND_SAMPLE, 14'h3FFF, 16'sh8000);
        // codebook write between samples keeps the vector going
        push_word(KIND_CODEBOOK, 33, 16'sh7FFF);
        // largest distances everywhere but centroid 15; odd count ends on a lone low nibble
        push_word(KIND_SAMPLE, 0, 16'sh8000);
        // second vector stops after two subspaces and is restarted below
        push_word(KIND_SAMPLE, 14'h2AAA, 16'sh0000);
        push_word(KIND_SAMPLE, 14'h1555, 16'shFFFF);
        wait_quiet();

        // Zero in both registers reads as one: every sample ends a vector
        cfg_write(CFG_SUB_COUNT, 0);
        cfg_write(CFG_SUB_LENGTH, 0);
        push_word(KIND_SAMPLE, 0, 16'sh7FFF);
        push_word(KIND_SAMPLE, 0, 16'sh8000);
        push_word(KIND_SAMPLE, 0, 16'sh0001);
        wait_quiet();

        // Length with only upper bits set masks down to zero
        cfg_write(CFG_SUB_LENGTH, 11'h780);
        cfg_write(CFG_SUB_COUNT, 2);
        push_word(KIND_SAMPLE, 0, 16'sh4000);
        push_word(KIND_SAMPLE, 0, 16'shC000);

        random_segment(SEG_ITEMS);

        // Sender idles most of the time, receiver now and then
        send_gap_pct   = 64;
        recv_stall_pct = 24;
        random_segment(SEG_ITEMS);

        // Full rate on both sides
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        random_segment(SEG_ITEMS);

        wait_quiet();
        if (err_count == 0) begin
            $display("pq_nibble_encoder test passed");
        end else begin
            $display("pq_nibble_encoder test failed");
        end
        $finish;
    end

endmodule
